// ----- rtl/bvm_pkg.sv -----
package bvm_pkg;

    // field and datapath widths
    localparam int ADC_W      = 10;
    localparam int MV_W       = 14;
    localparam int LED_W      = 8;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 13;
    localparam int INTERVAL_W = 16;
    localparam int SCALE_W    = 8;
    localparam int WARN_W     = 7;
    localparam int PROD_W     = 2 * MV_W;
    localparam int PCT_PROD_W = 21;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // serial engine step counts
    localparam int MUL_STEPS = ADC_W;
    localparam int DIV_STEPS = MV_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING          = 2'd2;

    // register reset values and legal ranges
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [SCALE_W-1:0]    SCALE_RESET    = 8'd100;
    localparam logic [SCALE_W-1:0]    SCALE_MIN      = 8'd50;
    localparam logic [SCALE_W-1:0]    SCALE_MAX      = 8'd150;
    localparam logic [WARN_W-1:0]     WARN_RESET     = 7'd80;
    localparam logic [WARN_W-1:0]     WARN_MIN       = 7'd10;
    localparam logic [WARN_W-1:0]     WARN_MAX       = 7'd100;

    // arithmetic constants
    localparam logic [MV_W-1:0]     ADC_MAX_CODE = 14'd1023;
    localparam logic [MV_W-1:0]     PCT_DIV      = 14'd100;
    localparam logic [ADC_W-1:0]    LEVEL_GAIN   = 10'd255;
    localparam logic [LED_W-1:0]    LED_MAX      = 8'd255;
    localparam logic [PERIOD_W-1:0] PERIOD_SLOW  = 13'd5000;
    localparam logic [PERIOD_W-1:0] PERIOD_FAST  = 13'd500;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  adc_sample;
    } in_item_t;

    typedef struct packed {
        logic             measured;
        logic [MV_W-1:0]  battery_mv;
        logic [LED_W-1:0] led_level;
        logic             beep;
    } out_item_t;

    // request to the serial multiply-divide engine: (a * b) / d
    typedef struct packed {
        logic             start;
        logic [MV_W-1:0]  a;
        logic [ADC_W-1:0] b;
        logic [MV_W-1:0]  d;
    } md_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [MV_W-1:0] quotient;
    } md_sts_t;

endpackage

// ----- rtl/bvm_muldiv.sv -----
module bvm_muldiv
    import bvm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_sts_t sts
);

    typedef enum logic [1:0] {
        PH_MUL = 2'b01,
        PH_DIV = 2'b10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]  w_reg, w_next;
    logic [MV_W-1:0]    a_reg, a_next;
    logic [ADC_W-1:0]   b_reg, b_next;
    logic [MV_W-1:0]    d_reg, d_next;
    logic [MV_W:0]      trial;
    logic [MV_W:0]      diff;
    logic               fits;
    logic [MV_W-1:0]    rem;

    // partial remainder shifted left with the next dividend bit
    assign trial = w_reg[PROD_W-1:MV_W-1];
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};
    assign rem   = fits ? diff[MV_W-1:0] : trial[MV_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        if (req.start && !busy_reg)
        begin
            a_next     = req.a;
            b_next     = req.b;
            d_next     = req.d;
            w_next     = '0;
            cnt_next   = '0;
            phase_next = PH_MUL;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                PH_MUL:
                begin
                    // shift-add, multiplier bits msb first
                    w_next = {w_reg[PROD_W-2:0], 1'b0}
                             + (b_reg[ADC_W-1] ? PROD_W'(a_reg) : '0);
                    b_next = {b_reg[ADC_W-2:0], 1'b0};
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    begin
                        cnt_next   = '0;
                        phase_next = PH_DIV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                PH_DIV:
                begin
                    // restoring division, quotient bits enter at the bottom
                    w_next = {rem, w_reg[MV_W-2:0], fits};
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_MUL;
                    busy_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MUL;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        a_reg <= a_next;
        b_reg <= b_next;
        d_reg <= d_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = w_reg[MV_W-1:0];

endmodule

// ----- rtl/battery_voltage_monitor_top.sv -----
// a tick that takes no measurement goes from acceptance straight to evaluation; a measuring
// tick first runs three serial multiply-divide passes (conversion, scale, level) on the
// bit-serial shift-add / restoring-divide engine (10 + 14 steps per pass); the result is
// registered in the output stage once that stage is free; one tick is taken at a time
// reset: asynchronous active-low rst_n restores register defaults and clears the control
// and monitor state; the payload registers and the engine datapath are not reset
module battery_voltage_monitor_top
    import bvm_pkg::*;
#(
    parameter int FULL_SCALE_MV = 10750,
    parameter int NOMINAL_MV    = 8400,
    parameter int DEAD_PCT      = 60
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // limits compared as 100 * mv <= pct * nominal, which equals mv <= pct * nominal / 100
    localparam logic [PCT_PROD_W-1:0] DEAD_PROD  = PCT_PROD_W'(DEAD_PCT * NOMINAL_MV);
    localparam logic [PCT_PROD_W-1:0] WARN_PROD0 = PCT_PROD_W'(80 * NOMINAL_MV);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_OP   = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    // which multiply-divide pass is running
    typedef enum logic [1:0] {
        OP_CONV  = 2'd0,   // sample * full scale / 1023
        OP_SCALE = 2'd1,   // mv * scale / 100
        OP_LEVEL = 2'd2    // mv * 255 / nominal
    } op_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;

    // configuration
    logic [INTERVAL_W-1:0]   interval_reg, interval_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;
    logic [PCT_PROD_W-1:0]   warn_prod_reg, warn_prod_next;

    // monitor state
    logic [MV_W-1:0]         volt_reg, volt_next;
    logic [PCT_PROD_W-1:0]   volt100_reg, volt100_next;
    logic [TIME_W-1:0]       last_meas_reg, last_meas_next;
    logic [TIME_W-1:0]       last_warn_reg, last_warn_next;
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic [LED_W-1:0]        led_reg, led_next;
    logic [LED_W-1:0]        saved_reg, saved_next;

    // per-transaction working registers
    logic [TIME_W-1:0]       now_reg, now_next;
    logic                    meas_reg, meas_next;
    logic [MV_W-1:0]         mv_reg, mv_next;
    logic [PCT_PROD_W-1:0]   mv100_reg, mv100_next;

    // output stage
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    md_req_t                 md_req;
    md_sts_t                 md_sts;

    logic                    in_fire;
    logic                    out_free;
    logic                    meas_due;
    logic [TIME_W-1:0]       meas_age;
    logic [TIME_W-1:0]       warn_age;
    logic [MV_W-1:0]         cur_volt;
    logic [PCT_PROD_W-1:0]   cur100;
    logic                    lvl_over;
    logic                    is_dead;
    logic                    is_warn;
    logic [LED_W-1:0]        lvl_led;
    logic [PERIOD_W-1:0]     eval_period;
    logic [LED_W-1:0]        eval_led;
    logic                    blink;

    bvm_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .sts   (md_sts)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign meas_age = in_data.now_ms - last_meas_reg;
    assign meas_due = TIME_W'(interval_reg) <= meas_age;

    // evaluation of one tick from registered values
    assign cur_volt = meas_reg ? mv_reg : volt_reg;
    assign cur100   = meas_reg ? mv100_reg : volt100_reg;
    assign lvl_over = md_sts.quotient[MV_W-1:LED_W] != '0;
    assign is_dead  = mv100_reg <= DEAD_PROD;
    assign is_warn  = cur100 <= warn_prod_reg;
    assign warn_age = now_reg - last_warn_reg;

    always_comb
    begin
        eval_period = period_reg;
        eval_led    = led_reg;
        lvl_led     = md_sts.quotient[LED_W-1:0];
        if (meas_reg)
        begin
            if (lvl_over)
            begin
                eval_period = PERIOD_SLOW;
                lvl_led     = LED_MAX;
            end
            else if (is_dead)
            begin
                eval_period = PERIOD_FAST;
                lvl_led     = '0;
            end
            else if (is_warn)
            begin
                eval_period = PERIOD_FAST;
            end
            eval_led = lvl_led;
        end
    end

    assign blink = (cur_volt != '0) && is_warn && (TIME_W'(eval_period) <= warn_age);

    // configuration writes, out-of-range values dropped
    always_comb
    begin
        interval_next  = interval_reg;
        scale_next     = scale_reg;
        warn_prod_next = warn_prod_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MEASURE_INTERVAL:
                begin
                    interval_next = cfg_data[INTERVAL_W-1:0];
                end
                CFG_VOLTAGE_SCALE:
                begin
                    if (cfg_data[SCALE_W-1:0] >= SCALE_MIN && cfg_data[SCALE_W-1:0] <= SCALE_MAX)
                    begin
                        scale_next = cfg_data[SCALE_W-1:0];
                    end
                end
                CFG_WARNING:
                begin
                    if (cfg_data[WARN_W-1:0] >= WARN_MIN && cfg_data[WARN_W-1:0] <= WARN_MAX)
                    begin
                        warn_prod_next = PCT_PROD_W'(cfg_data[WARN_W-1:0])
                                         * PCT_PROD_W'(NOMINAL_MV);
                    end
                end
                default:
                begin
                    interval_next = interval_reg;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        meas_next      = meas_reg;
        mv_next        = mv_reg;
        mv100_next     = mv100_reg;
        volt_next      = volt_reg;
        volt100_next   = volt100_reg;
        last_meas_next = last_meas_reg;
        last_warn_next = last_warn_reg;
        period_next    = period_reg;
        led_next       = led_reg;
        saved_next     = saved_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        md_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    now_next  = in_data.now_ms;
                    meas_next = meas_due;
                    if (meas_due)
                    begin
                        md_req.start = 1'b1;
                        md_req.a     = MV_W'(FULL_SCALE_MV);
                        md_req.b     = in_data.adc_sample;
                        md_req.d     = ADC_MAX_CODE;
                        op_next      = OP_CONV;
                        state_next   = ST_OP;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_OP:
            begin
                if (md_sts.done)
                begin
                    case (op_reg)
                        OP_CONV:
                        begin
                            md_req.start = 1'b1;
                            md_req.a     = md_sts.quotient;
                            md_req.b     = ADC_W'(scale_reg);
                            md_req.d     = PCT_DIV;
                            op_next      = OP_SCALE;
                        end
                        OP_SCALE:
                        begin
                            // keep mv and 100 * mv for the limit compares
                            mv_next      = md_sts.quotient;
                            mv100_next   = (PCT_PROD_W'(md_sts.quotient) << 6)
                                           + (PCT_PROD_W'(md_sts.quotient) << 5)
                                           + (PCT_PROD_W'(md_sts.quotient) << 2);
                            md_req.start = 1'b1;
                            md_req.a     = md_sts.quotient;
                            md_req.b     = LEVEL_GAIN;
                            md_req.d     = MV_W'(NOMINAL_MV);
                            op_next      = OP_LEVEL;
                        end
                        default:
                        begin
                            // level quotient stays in the engine until the next start
                            state_next = ST_EVAL;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                // commit only when the output stage can take the transaction
                if (out_free)
                begin
                    volt_next    = cur_volt;
                    volt100_next = cur100;
                    period_next  = eval_period;
                    led_next     = eval_led;
                    if (meas_reg)
                    begin
                        last_meas_next = now_reg;
                    end
                    if (blink)
                    begin
                        last_warn_next = now_reg;
                        if (saved_reg == '0)
                        begin
                            saved_next = eval_led;
                            led_next   = '0;
                        end
                        else
                        begin
                            led_next   = saved_reg;
                            saved_next = '0;
                        end
                    end
                    out_valid_next           = 1'b1;
                    out_data_next.measured   = meas_reg;
                    out_data_next.battery_mv = cur_volt;
                    out_data_next.led_level  = led_next;
                    out_data_next.beep       = blink;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_CONV;
            interval_reg  <= INTERVAL_RESET;
            scale_reg     <= SCALE_RESET;
            warn_prod_reg <= WARN_PROD0;
            volt_reg      <= '0;
            volt100_reg   <= '0;
            last_meas_reg <= '0;
            last_warn_reg <= '0;
            period_reg    <= PERIOD_SLOW;
            led_reg       <= '0;
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            interval_reg  <= interval_next;
            scale_reg     <= scale_next;
            warn_prod_reg <= warn_prod_next;
            volt_reg      <= volt_next;
            volt100_reg   <= volt100_next;
            last_meas_reg <= last_meas_next;
            last_warn_reg <= last_warn_next;
            period_reg    <= period_next;
            led_reg       <= led_next;
            saved_reg     <= saved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        meas_reg     <= meas_next;
        mv_reg       <= mv_next;
        mv100_reg    <= mv100_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the engine never runs while a new transaction can be taken
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !md_sts.busy)
        else $error("muldiv busy while idle");

    // engine results arrive only while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n) md_sts.done |-> state_reg == ST_OP)
        else $error("muldiv done outside op state");

    // a beep needs a nonzero voltage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.beep |-> out_data.battery_mv != '0)
        else $error("beep with zero voltage");

    // a fresh zero reading is a dead battery, so the led is off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.measured && out_data.battery_mv == '0 |-> out_data.led_level == '0)
        else $error("led on at zero voltage");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bvm_pkg::*;

    // block parameters, passed to the instance so the predictor sees the same values
    localparam int FULL_SCALE_MV = 10750;
    localparam int NOMINAL_MV    = 8400;
    localparam int DEAD_PCT      = 60;
    localparam int DEAD_LIMIT_MV = DEAD_PCT * NOMINAL_MV / 100;

    // register index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int NUM_PHASES       = 8;
    localparam int TICKS_PER_PHASE  = 50;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 100;   // longer than a measuring tick takes without an output stall
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no transaction on any channel
    localparam int MAX_REPORTS      = 10;

    // one row of the directed table: the tick, plus a typed result where it is obvious
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  adc_sample;
        logic              has_want;
        out_item_t         want;
    } dir_row_t;

    // defaults after reset: interval 1000 ms, scale 100 %, warning at 6720 mV, dead at 5040 mV
    localparam dir_row_t DIR_ROWS [16] = '{
        // first tick after reset: interval not yet elapsed, nothing shown
        '{32'd0,          10'd0,    1'b1, '{1'b0, 14'd0,     8'd0,   1'b0}},
        // one millisecond short of the interval
        '{32'd999,        10'd1023, 1'b1, '{1'b0, 14'd0,     8'd0,   1'b0}},
        // full-scale reading: level saturates, slow blink, no warning
        '{32'd1000,       10'd1023, 1'b1, '{1'b1, 14'd10750, 8'd255, 1'b0}},
        // zero voltage: dead zone but blinking stays off
        '{32'd2000,       10'd0,    1'b1, '{1'b1, 14'd0,     8'd0,   1'b0}},
        // dead battery, first toggle saves a level of zero
        '{32'd3000,       10'd479,  1'b0, '0},
        // saved level is zero, so the next toggle saves again
        '{32'd3500,       10'd479,  1'b0, '0},
        // warning zone, led goes dark and the level is saved
        '{32'd4000,       10'd600,  1'b0, '0},
        // next toggle restores the saved level
        '{32'd4500,       10'd600,  1'b0, '0},
        // normal zone keeps the fast period but no warning
        '{32'd5000,       10'd700,  1'b0, '0},
        '{32'd6000,       10'd1023, 1'b0, '0},
        '{32'd7000,       10'd620,  1'b0, '0},
        // time at its maximum, then wrapping past zero
        '{32'hFFFF_FFFF,  10'd1023, 1'b0, '0},
        '{32'h0000_0200,  10'd620,  1'b0, '0},
        '{32'h0000_0400,  10'd620,  1'b0, '0},
        '{32'h0000_07E8,  10'd1,    1'b0, '0},
        '{32'h0000_0BCF,  10'd1023, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the registers
    logic [INTERVAL_W-1:0] interval_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [WARN_W-1:0]     warn_reg;

    // predictor copy of the block state
    logic [MV_W-1:0]     battery_volt;
    logic [TIME_W-1:0]   last_measure_ms;
    logic [TIME_W-1:0]   last_warning_ms;
    logic [PERIOD_W-1:0] blink_period;
    logic [LED_W-1:0]    led_drive;
    logic [LED_W-1:0]    saved_led;

    // readings predicted for accepted ticks, oldest first
    out_item_t expected_readings[$];

    // stimulus controls for the source and the receiver process
    bit src_idle_on;
    bit sink_idle_on;
    bit long_hold_req;

    logic [TIME_W-1:0] tick_clock;
    int                idle_cycles;
    int                bad_results;
    int                n_ticks;
    int                n_measured;
    int                n_beeps;
    int                n_reg_writes;

    battery_voltage_monitor_top #(
        .FULL_SCALE_MV (FULL_SCALE_MV),
        .NOMINAL_MV    (NOMINAL_MV),
        .DEAD_PCT      (DEAD_PCT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // register write as seen by the block: field masking, out-of-range values dropped
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MEASURE_INTERVAL:
                interval_reg = val[INTERVAL_W-1:0];
            CFG_VOLTAGE_SCALE:
                if (val[SCALE_W-1:0] >= SCALE_MIN && val[SCALE_W-1:0] <= SCALE_MAX)
                    scale_reg = val[SCALE_W-1:0];
            CFG_WARNING:
                if (val[WARN_W-1:0] >= WARN_MIN && val[WARN_W-1:0] <= WARN_MAX)
                    warn_reg = val[WARN_W-1:0];
            default:
                ;
        endcase
    endtask

    // one millisecond tick: optional measurement, then the warning blink
    function automatic out_item_t predict_monitor_tick(input in_item_t tick);
        out_item_t         res;
        int unsigned       warn_limit;
        int unsigned       mv;
        int unsigned       level;
        logic [TIME_W-1:0] since_measure;
        logic [TIME_W-1:0] since_warning;
        res           = '0;
        warn_limit    = int'(warn_reg) * NOMINAL_MV / 100;
        since_measure = tick.now_ms - last_measure_ms;
        if (TIME_W'(interval_reg) <= since_measure)
        begin
            mv    = tick.adc_sample;
            mv    = mv * FULL_SCALE_MV / ADC_MAX_CODE;
            mv    = (mv * scale_reg / PCT_DIV) & 32'h3FFF;
            level = mv * LEVEL_GAIN / NOMINAL_MV;
            battery_volt = mv[MV_W-1:0];
            if (level > LED_MAX)
            begin
                blink_period = PERIOD_SLOW;
                level        = LED_MAX;
            end
            else if (mv <= DEAD_LIMIT_MV)
            begin
                blink_period = PERIOD_FAST;
                level        = 0;
            end
            else if (mv <= warn_limit)
                blink_period = PERIOD_FAST;
            led_drive       = level[LED_W-1:0];
            last_measure_ms = tick.now_ms;
            res.measured    = 1'b1;
        end
        since_warning = tick.now_ms - last_warning_ms;
        if (battery_volt != 0 && battery_volt <= warn_limit &&
            TIME_W'(blink_period) <= since_warning)
        begin
            // toggle between dark and the saved level
            if (saved_led == 0)
            begin
                saved_led = led_drive;
                led_drive = '0;
            end
            else
            begin
                led_drive = saved_led;
                saved_led = '0;
            end
            res.beep        = 1'b1;
            last_warning_ms = tick.now_ms;
        end
        res.battery_mv = battery_volt;
        res.led_level  = led_drive;
        return res;
    endfunction

    // next tick time: mostly forward steps, around the interval and the blink period
    function automatic logic [TIME_W-1:0] next_tick_time(input logic [TIME_W-1:0] now);
        case ($urandom_range(0, 11))
            0:       return $urandom;                                  // jump anywhere
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 1500);   // close to the wrap
            2, 3:    return now + interval_reg + $urandom_range(0, 3);
            4:       return now + interval_reg - 1;
            5, 6:    return now + $urandom_range(495, 505);
            default: return now + $urandom_range(0, 400);
        endcase
    endfunction

    // adc code: mostly aimed around the dead and warning limits at the current scale
    function automatic logic [ADC_W-1:0] pick_sample();
        int unsigned     warn_limit;
        int unsigned     lo;
        int unsigned     hi;
        longint unsigned code;
        warn_limit = int'(warn_reg) * NOMINAL_MV / 100;
        lo = (warn_limit < DEAD_LIMIT_MV) ? warn_limit : DEAD_LIMIT_MV;
        hi = (warn_limit > DEAD_LIMIT_MV) ? warn_limit : DEAD_LIMIT_MV;
        lo = (lo > 300) ? lo - 300 : 0;
        hi = hi + 300;
        case ($urandom_range(0, 4))
            0, 1:
                return $urandom_range(0, 1023);
            default:
            begin
                code = longint'($urandom_range(hi, lo)) * ADC_MAX_CODE * PCT_DIV /
                       (longint'(FULL_SCALE_MV) * scale_reg);
                if (code > ADC_MAX_CODE)
                    code = ADC_MAX_CODE;
                return code[ADC_W-1:0];
            end
        endcase
    endfunction

    // offer one tick, predict its reading at acceptance; valid stays high afterward
    task automatic send_tick(input in_item_t tick, input logic has_want, input out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (!in_ready);
        predicted = predict_monitor_tick(tick);
        expected_readings.push_back(has_want ? want : predicted);
        n_ticks++;
    endtask

    // register write transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        n_reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering and let every predicted reading come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls per transaction, plus one long hold-off on request
    initial
    begin
        int unsigned hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                hold          = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else
                hold = sink_idle_on ? $urandom_range(0, 7) : 0;
            @(negedge clk);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // result checker: every reading against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (out_data.measured === 1'b1)
                n_measured++;
            if (out_data.beep === 1'b1)
                n_beeps++;
            if (expected_readings.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("%0t: reading with no tick waiting: measured %b mv %0d led %0d beep %b",
                             $realtime, out_data.measured, out_data.battery_mv,
                             out_data.led_level, out_data.beep);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (out_data.measured !== want.measured ||
                    out_data.battery_mv !== want.battery_mv ||
                    out_data.led_level !== want.led_level ||
                    out_data.beep !== want.beep)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("%0t: reading mismatch: expected measured %b mv %0d led %0d beep %b, got measured %b mv %0d led %0d beep %b",
                                 $realtime, want.measured, want.battery_mv, want.led_level,
                                 want.beep, out_data.measured, out_data.battery_mv,
                                 out_data.led_level, out_data.beep);
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, giving up", $realtime, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // main sequence: reset, directed table, then randomized phases per register setting
    initial
    begin
        in_item_t              tick;
        logic [INTERVAL_W-1:0] interval;
        logic [SCALE_W-1:0]    scale;
        logic [SCALE_W-1:0]    bad_scale;
        logic [WARN_W-1:0]     warn;
        logic [WARN_W-1:0]     bad_warn;

        // all inputs known from time zero, reset held low
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MEASURE_INTERVAL;
        cfg_data      = '0;
        long_hold_req = 1'b0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        idle_cycles   = 0;
        bad_results   = 0;
        n_ticks       = 0;
        n_measured    = 0;
        n_beeps       = 0;
        n_reg_writes  = 0;

        // predictor reset state
        interval_reg    = INTERVAL_RESET;
        scale_reg       = SCALE_RESET;
        warn_reg        = WARN_RESET;
        battery_volt    = '0;
        last_measure_ms = '0;
        last_warning_ms = '0;
        blink_period    = PERIOD_SLOW;
        led_drive       = '0;
        saved_led       = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed table at reset register values
        foreach (DIR_ROWS[i])
        begin
            tick.now_ms     = DIR_ROWS[i].now_ms;
            tick.adc_sample = DIR_ROWS[i].adc_sample;
            send_tick(tick, DIR_ROWS[i].has_want, DIR_ROWS[i].want);
        end
        tick_clock = DIR_ROWS[15].now_ms;
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // register extremes and reset values first, then random settings
            case (p)
                0:
                begin
                    interval  = '0;            // measure every tick
                    scale     = SCALE_MAX;
                    warn      = WARN_MAX;
                    bad_scale = SCALE_MIN - 1;
                    bad_warn  = WARN_MAX + 1;
                end
                1:
                begin
                    interval  = '1;
                    scale     = SCALE_MIN;
                    warn      = WARN_MIN;
                    bad_scale = SCALE_MAX + 1;
                    bad_warn  = WARN_MIN - 1;
                end
                2:
                begin
                    interval  = 16'd500;
                    scale     = SCALE_RESET;
                    warn      = WARN_RESET;
                    bad_scale = '1;
                    bad_warn  = '1;
                end
                default:
                begin
                    interval  = $urandom_range(0, 1200);
                    scale     = $urandom_range(SCALE_MIN, SCALE_MAX);
                    warn      = $urandom_range(WARN_MIN, WARN_MAX);
                    bad_scale = $urandom_range(0, 1) ? $urandom_range(0, SCALE_MIN - 1)
                                                     : $urandom_range(SCALE_MAX + 1, 255);
                    bad_warn  = $urandom_range(0, 1) ? $urandom_range(0, WARN_MIN - 1)
                                                     : $urandom_range(WARN_MAX + 1, 127);
                end
            endcase

            // dropped writes first, then the real setting with junk in the unused upper bits
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            write_reg(CFG_VOLTAGE_SCALE, {8'($urandom), bad_scale});
            write_reg(CFG_WARNING, {9'($urandom), bad_warn});
            write_reg(CFG_MEASURE_INTERVAL, interval);
            write_reg(CFG_VOLTAGE_SCALE, {8'($urandom), scale});
            write_reg(CFG_WARNING, {9'($urandom), warn});

            // idling pattern per phase, with none at all in phases 1, 4 and 7
            src_idle_on  = (p % 3 == 0);
            sink_idle_on = (p % 3 != 1);

            // mostly short non-measuring ticks here, so a long receiver stall backs up the input
            if (p == 2)
                long_hold_req = 1'b1;

            for (int k = 0; k < TICKS_PER_PHASE; k++)
            begin
                tick_clock      = next_tick_time(tick_clock);
                tick.now_ms     = tick_clock;
                tick.adc_sample = pick_sample();
                send_tick(tick, 1'b0, '0);
            end
            wait_idle();
        end

        // nothing outstanding; give any stray reading time to show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d ticks over %0d register settings, %0d register writes",
                 n_ticks, NUM_PHASES + 1, n_reg_writes);
        $display("saw %0d measurements and %0d warning beeps, %0d bad readings, %0d missing",
                 n_measured, n_beeps, bad_results, expected_readings.size());
        if (bad_results == 0 && expected_readings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bvm_pkg.sv
rtl/bvm_muldiv.sv
rtl/battery_voltage_monitor_top.sv
verif/tb.sv
